// ===== hdl/hdce_pkg.sv =====
// ---------------------------------------------------------------------------
// hdce_pkg
// Shared types and constants of the highest-degree cluster election block.
// ---------------------------------------------------------------------------
package hdce_pkg;

    // node id width and stream widths
    localparam int ID_BITS     = 16;
    localparam int IN_TDATA_W  = ((32 + ID_BITS + 27 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] ROLE_UNDECIDED = 2'd0;
    localparam logic [1:0] ROLE_MEMBER    = 2'd1;
    localparam logic [1:0] ROLE_HEAD      = 2'd2;
    localparam logic [1:0] ROLE_GATEWAY   = 2'd3;

    localparam logic signed [16:0] NO_HEAD = -17'sd1;

    localparam logic ACT_BEACON = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // register indexes of the configuration port
    localparam logic REG_OWN_ID   = 1'b0;
    localparam logic REG_VALIDITY = 1'b1;

    // one result item
    typedef struct packed {
        logic [31:0]        head_lifetime;
        logic               lifetime_valid;
        logic               role_changed;
        logic [5:0]         bridged;
        logic [5:0]         cluster_size;
        logic [5:0]         degree;
        logic signed [16:0] head_id;
        logic [1:0]         role;
    } t_result;

endpackage

// ===== hdl/hdce_table.sv =====
// ---------------------------------------------------------------------------
// hdce_table
// Neighbour table: synchronous memory of entries with per-entry valid bits.
// ---------------------------------------------------------------------------
module hdce_table #(
    parameter int NEIGHBORS = 32,
    parameter int ID_BITS   = 16,
    parameter int AW        = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [AW-1:0]      i_raddr,
    output logic [ID_BITS-1:0] o_rid,
    output logic [7:0]         o_rdeg,
    output logic [1:0]         o_rrole,
    output logic signed [16:0] o_rhead,
    output logic [31:0]        o_rseen,
    output logic               o_rvalid,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ID_BITS-1:0] i_wid,
    input  logic [7:0]         i_wdeg,
    input  logic [1:0]         i_wrole,
    input  logic signed [16:0] i_whead,
    input  logic [31:0]        i_wseen,
    input  logic               i_vclr,
    input  logic [AW-1:0]      i_vaddr
);

    localparam int EW = ID_BITS + 8 + 2 + 17 + 32;

    logic [EW-1:0]        mem [NEIGHBORS];
    logic [EW-1:0]        r_rdata;
    logic [NEIGHBORS-1:0] r_valid;
    logic                 r_rvalid;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wid, i_wdeg, i_wrole, i_whead, i_wseen};
        end
        r_rdata <= mem[i_raddr];
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_raddr] && !(i_vclr && i_vaddr == i_raddr);
            if (i_vclr) begin
                r_valid[i_vaddr] <= 1'b0;
            end
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign {o_rid, o_rdeg, o_rrole, o_rhead, o_rseen} = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

// ===== hdl/highest_degree_cluster_election_top.sv =====
// ---------------------------------------------------------------------------
// highest_degree_cluster_election_top
// Highest-connectivity clustering node with a neighbour table in memory.
// ---------------------------------------------------------------------------
// Input channel s_axis: one transaction per beacon or tick. Beacons update
// the neighbour table and give no result; ticks expire stale entries, elect
// a head and give one result transaction on m_axis.
// Sequence: a beacon runs one table scan for a match or free slot, then a
// write; a beacon from the node's own id is dropped on accept. A tick runs
// a first scan that expires entries, counts degree, cluster size and the
// best neighbour, then a second scan that settles the election against the
// own degree and counts distinct clusters into a small cluster list. The
// memory read port gives one entry per cycle.
// One item is in work at a time; s_axis_tready is low while busy or while
// a result waits in the output register. A stalled receiver holds the
// result and the block takes no further item.
// Reset clears all valid bits, the role (undecided), head (-1), degree and
// head start time; the table contents need no clearing.
// Configuration: APB, own_id at 0x0, validity_ticks at 0x4, write when idle.
// ---------------------------------------------------------------------------
module highest_degree_cluster_election_top #(
    parameter int NEIGHBORS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: now_ticks[31:0], sender_id, sender_degree[8], sender_role[2],
    // sender_head[17], zero fill
    input  logic [hdce_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: role[2], head_id[17], degree[6], cluster_size[6], bridged[6],
    // role_changed, lifetime_valid, head_lifetime[32], zero fill
    output logic [hdce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ID_BITS = hdce_pkg::ID_BITS;
    localparam int AW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CW  = $clog2(NEIGHBORS + 2);
    localparam int DW  = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BSCAN = 3'd1;
    localparam logic [2:0] S_TSCAN = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // configuration registers
    logic [ID_BITS-1:0] r_own_id;
    logic [31:0]        r_validity;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id   <= '0;
            r_validity <= 32'd1000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                hdce_pkg::REG_OWN_ID:   r_own_id   <= pwdata[ID_BITS-1:0];
                hdce_pkg::REG_VALIDITY: r_validity <= pwdata;
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[2])
            hdce_pkg::REG_OWN_ID:   prdata = 32'(r_own_id);
            default:                prdata = r_validity;
        endcase
    end

    // latched input item
    logic               r_act;
    logic [31:0]        r_now;
    logic [ID_BITS-1:0] r_sid;
    logic [7:0]         r_sdeg;
    logic [1:0]         r_srole;
    logic signed [16:0] r_shead;

    // control
    logic [2:0]  r_state;
    logic [AW:0] r_cnt;     // issued read address count
    logic        r_rd;      // read data valid this cycle
    logic [AW-1:0] r_ra;    // address of data now on the read port
    logic        r_last;
    logic        w_scan;

    // beacon scan results
    logic          r_match, r_free;
    logic [AW-1:0] r_mslot, r_fslot;

    // tick scan results
    logic [CW-1:0]      r_count, r_csize, r_nclu;
    logic [7:0]         r_bdeg;
    logic [ID_BITS-1:0] r_bid;
    logic signed [16:0] r_clu [NEIGHBORS];

    // own state
    logic [1:0]  r_role;
    logic signed [16:0] r_head;
    logic [5:0]  r_deg;
    logic [31:0] r_since;

    // output register
    logic                 r_ovalid;
    hdce_pkg::t_result    r_out;

    // table
    logic [ID_BITS-1:0] t_id;
    logic [7:0]         t_deg;
    logic [1:0]         t_role;
    logic signed [16:0] t_head;
    logic [31:0]        t_seen;
    logic               t_valid;
    logic               w_we, w_vclr;
    logic [AW-1:0]      w_waddr;

    hdce_table #(.NEIGHBORS(NEIGHBORS), .ID_BITS(ID_BITS), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rid   (t_id),
        .o_rdeg  (t_deg),
        .o_rrole (t_role),
        .o_rhead (t_head),
        .o_rseen (t_seen),
        .o_rvalid(t_valid),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wid   (r_sid),
        .i_wdeg  (r_sdeg),
        .i_wrole (r_srole),
        .i_whead (r_shead),
        .i_wseen (r_now),
        .i_vclr  (w_vclr),
        .i_vaddr (r_ra)
    );

    // entry liveness during the first tick scan
    logic [31:0] w_age;
    logic        w_live, w_exp;
    assign w_age  = r_now - t_seen;
    assign w_exp  = t_valid && (w_age > r_validity);
    assign w_live = t_valid && !w_exp;
    assign w_vclr = (r_state == S_TSCAN) && r_rd && w_exp;

    // beacon write at the end of the scan
    assign w_we    = (r_state == S_FIN) && !r_act && (r_match || r_free);
    assign w_waddr = r_match ? r_mslot : r_fslot;

    // any of the three table scans
    assign w_scan = (r_state == S_BSCAN) || (r_state == S_TSCAN) ||
                    (r_state == S_CSCAN);

    // cluster naming for the second scan, the elected head counts as seen
    logic               w_has;
    logic signed [16:0] w_c;
    logic               w_seen;
    always_comb begin
        w_has = 1'b0;
        w_c   = t_head;
        if (t_role == hdce_pkg::ROLE_HEAD) begin
            w_has = 1'b1;
            w_c   = $signed({1'b0, 16'(t_id)});
        end else if (t_head != hdce_pkg::NO_HEAD) begin
            w_has = 1'b1;
        end
        w_seen = (w_c == $signed({1'b0, 16'(r_bid)}));
        for (int k = 0; k < NEIGHBORS; k++) begin
            if (k < int'(r_nclu) && r_clu[k] == w_c) w_seen = 1'b1;
        end
    end

    // election outcome, the list holds the clusters beside the elected head
    logic [1:0]  w_nrole;
    always_comb begin
        if (r_bid == r_own_id) w_nrole = hdce_pkg::ROLE_HEAD;
        else if (r_nclu != '0) w_nrole = hdce_pkg::ROLE_GATEWAY;
        else w_nrole = hdce_pkg::ROLE_MEMBER;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd     <= 1'b0;
            r_last   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_role   <= hdce_pkg::ROLE_UNDECIDED;
            r_head   <= hdce_pkg::NO_HEAD;
            r_deg    <= '0;
            r_since  <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            r_rd   <= w_scan && (r_cnt < (AW+1)'(NEIGHBORS));
            r_last <= w_scan && (r_cnt == (AW+1)'(NEIGHBORS - 1));
            r_ra   <= r_cnt[AW-1:0];
            unique case (r_state) inside
                S_IDLE: begin
                    r_cnt <= '0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act   <= s_axis_tuser;
                        r_now   <= s_axis_tdata[31:0];
                        r_sid   <= s_axis_tdata[32 +: ID_BITS];
                        r_sdeg  <= s_axis_tdata[32+ID_BITS +: 8];
                        r_srole <= s_axis_tdata[40+ID_BITS +: 2];
                        r_shead <= $signed(s_axis_tdata[42+ID_BITS +: 17]);
                        r_match <= 1'b0;
                        r_free  <= 1'b0;
                        r_count <= '0;
                        r_csize <= '0;
                        r_bdeg  <= '0;
                        r_bid   <= '0;
                        r_nclu  <= '0;
                        if (s_axis_tuser == hdce_pkg::ACT_TICK) begin
                            r_state <= S_TSCAN;
                        end else if (s_axis_tdata[32 +: ID_BITS] != r_own_id) begin
                            r_state <= S_BSCAN;
                        end
                    end
                end
                S_BSCAN, S_TSCAN, S_CSCAN: begin
                    // issue reads, then consume returned entries
                    if (r_cnt < (AW+1)'(NEIGHBORS)) begin
                        r_cnt  <= r_cnt + 1'b1;
                    end
                    if (r_rd) begin
                        if (r_state == S_BSCAN) begin
                            if (t_valid && t_id == r_sid && !r_match) begin
                                r_match <= 1'b1;
                                r_mslot <= r_ra;
                            end
                            if (!t_valid && !r_free) begin
                                r_free  <= 1'b1;
                                r_fslot <= r_ra;
                            end
                        end else if (r_state == S_TSCAN) begin
                            if (w_live) begin
                                r_count <= r_count + 1'b1;
                                if (r_role == hdce_pkg::ROLE_HEAD &&
                                    t_head == $signed({1'b0, 16'(r_own_id)})) begin
                                    r_csize <= r_csize + 1'b1;
                                end
                                if (t_deg > r_bdeg ||
                                    (t_deg == r_bdeg && t_id > r_bid)) begin
                                    r_bdeg <= t_deg;
                                    r_bid  <= t_id;
                                end
                            end
                        end else begin
                            if (t_valid && w_has && !w_seen) begin
                                r_clu[r_nclu[AW-1:0]] <= w_c;
                                r_nclu                <= r_nclu + 1'b1;
                            end
                        end
                    end
                    if (r_last) begin
                        r_cnt <= '0;
                        if (r_state == S_TSCAN) begin
                            r_state <= S_CSCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                    // seed the best candidate with self before entries arrive
                    if (r_state == S_TSCAN && r_cnt == '0) begin
                        r_bid <= r_own_id;
                    end
                    // self competes with the final live count before any cluster read
                    if (r_state == S_CSCAN && r_cnt == '0) begin
                        if (!(DW'(r_bdeg) > DW'(r_count) ||
                              (DW'(r_bdeg) == DW'(r_count) && r_bid > r_own_id))) begin
                            r_bid <= r_own_id;
                        end
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_cnt   <= '0;
                    if (r_act == hdce_pkg::ACT_TICK) begin
                        r_out.role           <= w_nrole;
                        r_out.head_id        <= $signed({1'b0, 16'(r_bid)});
                        r_out.degree         <= 6'(r_count);
                        r_out.cluster_size   <= (r_role == hdce_pkg::ROLE_HEAD) ?
                                                6'(r_csize + 1'b1) : 6'd0;
                        r_out.bridged        <= (w_nrole == hdce_pkg::ROLE_GATEWAY) ?
                                                6'(r_nclu + 1'b1) : 6'd0;
                        r_out.role_changed   <= (w_nrole != r_role);
                        r_out.lifetime_valid <= (w_nrole != r_role) &&
                                                (r_role == hdce_pkg::ROLE_HEAD);
                        r_out.head_lifetime  <= ((w_nrole != r_role) &&
                                                (r_role == hdce_pkg::ROLE_HEAD)) ?
                                                r_now - r_since : 32'd0;
                        r_ovalid <= 1'b1;
                        if (w_nrole != r_role && w_nrole == hdce_pkg::ROLE_HEAD) begin
                            r_since <= r_now;
                        end
                        r_role <= w_nrole;
                        r_head <= $signed({1'b0, 16'(r_bid)});
                        r_deg  <= 6'(r_count);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out.head_lifetime, r_out.lifetime_valid,
                            r_out.role_changed, r_out.bridged, r_out.cluster_size,
                            r_out.degree, r_out.head_id, r_out.role};

endmodule

// ===== bench/highest_degree_cluster_election_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// highest_degree_cluster_election_top_test
// Self-checking bench for the cluster election node: beacon and tick
// transactions are driven on s_axis, every tick result on m_axis is compared
// field by field with a local model of the neighbour table and the election.
// ---------------------------------------------------------------------------
module highest_degree_cluster_election_top_test;

    localparam int NB = 32;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    highest_degree_cluster_election_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // local copy of the node state
    bit                 nb_valid [NB];
    logic [15:0]        nb_id    [NB];
    logic [7:0]         nb_deg   [NB];
    logic [1:0]         nb_role  [NB];
    logic signed [16:0] nb_head  [NB];
    logic [31:0]        nb_seen  [NB];
    logic [1:0]         my_role;
    logic [31:0]        my_head_since;
    logic [15:0]        my_id;
    logic [31:0]        my_validity;

    hdce_pkg::t_result election_queue[$];
    int          fails;
    int          mismatches;
    bit          quiet;
    int          hold_req;
    logic [31:0] now_t;

    // neighbour table update on a beacon
    function automatic void learn_beacon(logic [15:0] sid, logic [7:0] deg,
                                         logic [1:0] role, logic [16:0] head,
                                         logic [31:0] now);
        int slot;
        slot = -1;
        if (sid == my_id) return;
        for (int i = 0; i < NB; i++)
            if (slot < 0 && nb_valid[i] && nb_id[i] == sid) slot = i;
        for (int i = 0; i < NB; i++)
            if (slot < 0 && !nb_valid[i]) slot = i;
        if (slot < 0) return;
        nb_valid[slot] = 1'b1;
        nb_id[slot]    = sid;
        nb_deg[slot]   = deg;
        nb_role[slot]  = role;
        nb_head[slot]  = head;
        nb_seen[slot]  = now;
    endfunction

    // expiry, election and cluster count on a tick
    function automatic hdce_pkg::t_result elect(logic [31:0] now);
        hdce_pkg::t_result r;
        int count, csize, best_deg, nclu;
        logic [15:0] best_id;
        logic [16:0] clus [NB + 1];
        logic [16:0] c;
        logic [1:0]  new_role;
        bit seen;
        count = 0;
        csize = 0;
        nclu = 0;
        r = '0;
        for (int i = 0; i < NB; i++) begin
            if (nb_valid[i] && (now - nb_seen[i]) > my_validity) nb_valid[i] = 1'b0;
            if (nb_valid[i]) count++;
        end
        if (my_role == hdce_pkg::ROLE_HEAD) begin
            csize = 1;
            for (int i = 0; i < NB; i++)
                if (nb_valid[i] && nb_head[i] == {1'b0, my_id}) csize++;
        end
        best_deg = count;
        best_id = my_id;
        for (int i = 0; i < NB; i++) begin
            if (!nb_valid[i]) continue;
            if (nb_deg[i] > best_deg) begin
                best_deg = nb_deg[i];
                best_id = nb_id[i];
            end else if (nb_deg[i] == best_deg && nb_id[i] > best_id) begin
                best_id = nb_id[i];
            end
        end
        if (best_id == my_id) begin
            new_role = hdce_pkg::ROLE_HEAD;
        end else begin
            clus[0] = {1'b0, best_id};
            nclu = 1;
            for (int i = 0; i < NB; i++) begin
                if (!nb_valid[i]) continue;
                if (nb_role[i] == hdce_pkg::ROLE_HEAD) c = {1'b0, nb_id[i]};
                else if (nb_head[i] != hdce_pkg::NO_HEAD) c = nb_head[i];
                else continue;
                seen = 0;
                for (int k = 0; k < nclu; k++) if (clus[k] == c) seen = 1;
                if (!seen) begin
                    clus[nclu] = c;
                    nclu++;
                end
            end
            if (nclu > 1) begin
                new_role = hdce_pkg::ROLE_GATEWAY;
                r.bridged = nclu[5:0];
            end else begin
                new_role = hdce_pkg::ROLE_MEMBER;
            end
        end
        if (new_role != my_role) begin
            r.role_changed = 1'b1;
            if (my_role == hdce_pkg::ROLE_HEAD) begin
                r.lifetime_valid = 1'b1;
                r.head_lifetime = now - my_head_since;
            end
            if (new_role == hdce_pkg::ROLE_HEAD) my_head_since = now;
            my_role = new_role;
        end
        r.role = my_role;
        r.head_id = {1'b0, best_id};
        r.degree = count[5:0];
        r.cluster_size = csize[5:0];
        return r;
    endfunction

    // receiver side: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        hdce_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = hdce_pkg::t_result'(m_axis_tdata[$bits(hdce_pkg::t_result)-1:0]);
            if (election_queue.size() == 0) begin
                fails++;
                if (mismatches++ < 10) $display("unexpected result %h", got);
            end else begin
                want = election_queue.pop_front();
                if (got !== want) begin
                    fails++;
                    if (mismatches++ < 10)
                        $display("mismatch: role %0d/%0d head %0d/%0d deg %0d/%0d ",
                                 want.role, got.role, want.head_id, got.head_id,
                                 want.degree, got.degree,
                                 "csize %0d/%0d bridged %0d/%0d chg %0d/%0d ",
                                 want.cluster_size, got.cluster_size,
                                 want.bridged, got.bridged,
                                 want.role_changed, got.role_changed,
                                 "lv %0d/%0d life %0d/%0d (expected/actual)",
                                 want.lifetime_valid, got.lifetime_valid,
                                 want.head_lifetime, got.head_lifetime);
                end
            end
        end
    end

    // one transaction on s_axis, with random idle cycles before it
    task automatic send_item(logic act, logic [31:0] now, logic [15:0] sid,
                             logic [7:0] deg, logic [1:0] role, logic [16:0] head);
        logic acc;
        if (!quiet && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, head, role, deg, sid, now};
        // tready is settled mid-cycle, the transaction happens at the next edge
        do begin
            @(negedge i_clk);
            acc = s_axis_tready;
            @(posedge i_clk);
        end while (!acc);
        if (act == hdce_pkg::ACT_TICK) election_queue.push_back(elect(now));
        else learn_beacon(sid, deg, role, head, now);
    endtask

    task automatic beacon(logic [15:0] sid, logic [7:0] deg, logic [1:0] role,
                          logic [16:0] head);
        send_item(hdce_pkg::ACT_BEACON, now_t, sid, deg, role, head);
    endtask

    task automatic tick();
        send_item(hdce_pkg::ACT_TICK, now_t, '0, '0, '0, '0);
    endtask

    // wait for every result, then for the beacon latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (election_queue.size() != 0);
        repeat (100) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hdce_pkg::REG_OWN_ID) my_id = value[15:0];
        else my_validity = value;
    endtask

    task automatic configure(logic [15:0] id, logic [31:0] validity);
        drain();
        write_reg(hdce_pkg::REG_OWN_ID, {16'd0, id});
        write_reg(hdce_pkg::REG_VALIDITY, validity);
    endtask

    // extremes of fields, own beacon, odd heads, expiry, stale self entry
    task automatic test_directed();
        configure(16'h1234, 32'd1000);
        now_t = 32'd5;
        tick();
        beacon(16'h1234, 8'd255, hdce_pkg::ROLE_HEAD, hdce_pkg::NO_HEAD);
        beacon(16'hFFFF, 8'd255, hdce_pkg::ROLE_GATEWAY, hdce_pkg::NO_HEAD);
        beacon(16'h0000, 8'd0, hdce_pkg::ROLE_HEAD, 17'h10000);
        beacon(16'h0042, 8'd3, hdce_pkg::ROLE_MEMBER, 17'h0FFFF);
        beacon(16'h0043, 8'd3, hdce_pkg::ROLE_UNDECIDED, 17'h01234);
        now_t = 32'd500;
        tick();
        beacon(16'hFFFF, 8'd1, hdce_pkg::ROLE_MEMBER, 17'h01234);
        tick();
        now_t = 32'd1506;
        tick();
        beacon(16'h0007, 8'd200, hdce_pkg::ROLE_HEAD, hdce_pkg::NO_HEAD);
        tick();
        configure(16'h0007, 32'd0);
        tick();
        now_t = 32'd1507;
        tick();
        configure(16'hFFFF, 32'hFFFF_FFFF);
        now_t = 32'hFFFF_FFF0;
        beacon(16'h0100, 8'd0, hdce_pkg::ROLE_MEMBER, 17'h1FFFE);
        tick();
        now_t = 32'h0000_0010;
        beacon(16'h0200, 8'd200, hdce_pkg::ROLE_HEAD, 17'h0FFFF);
        tick();
    endtask

    // full table: a new sender is dropped, a known one is overwritten
    task automatic test_table_full();
        configure(16'h0000, 32'd1);
        now_t = 32'd100000;
        tick();
        for (int i = 1; i <= NB + 1; i++)
            beacon(16'(i), 8'(i), hdce_pkg::ROLE_MEMBER, 17'(i % 3 + 1));
        tick();
        beacon(16'd5, 8'd250, hdce_pkg::ROLE_HEAD, hdce_pkg::NO_HEAD);
        tick();
        now_t += 2;
        tick();
    endtask

    // random item with ids from a small pool so entries are hit again
    task automatic random_item(int pool_base, int pool_size);
        logic [15:0] sid;
        logic [16:0] head;
        int sel;
        if ($urandom_range(99) < 20) begin
            now_t += $urandom_range(7);
            tick();
        end else begin
            sel = $urandom_range(99);
            if (sel < 5) sid = my_id;
            else if (sel < 10) sid = 16'($urandom);
            else sid = 16'(pool_base + $urandom_range(pool_size - 1));
            sel = $urandom_range(99);
            if (sel < 30) head = hdce_pkg::NO_HEAD;
            else if (sel < 50) head = {1'b0, my_id};
            else if (sel < 85) head = 17'(pool_base + $urandom_range(pool_size - 1));
            else head = 17'($urandom);
            now_t += $urandom_range(3);
            beacon(sid, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40)),
                   2'($urandom), head);
        end
    endtask

    task automatic test_random();
        logic [31:0] vals [6];
        vals = '{32'd1000, 32'd20, 32'd0, 32'hFFFF_FFFF, 32'd60, 32'd300};
        for (int p = 0; p < 6; p++) begin
            configure((p == 0) ? 16'h0000 : (p == 3) ? 16'hFFFF : 16'($urandom), vals[p]);
            now_t = (p == 4) ? 32'hFFFF_FF00 : $urandom;
            quiet = (p == 2);
            for (int n = 0; n < 270; n++)
                random_item(my_id + $urandom_range(1, 4) - 2, (p == 5) ? 6 : 40);
            quiet = 1'b0;
        end
    endtask

    // receiver holds off while beacons and ticks keep coming
    task automatic test_backpressure();
        configure(16'h00AA, 32'd500);
        hold_req = 400;
        for (int n = 0; n < 40; n++) random_item(16'h00A0, 24);
        drain();
        for (int n = 0; n < 40; n++) random_item(16'h00A0, 24);
    endtask

    initial begin
        fails = 0;
        mismatches = 0;
        quiet = 1'b0;
        hold_req = 0;
        now_t = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        my_id = '0;
        my_validity = 32'd1000;
        my_role = hdce_pkg::ROLE_UNDECIDED;
        my_head_since = '0;
        foreach (nb_valid[i]) nb_valid[i] = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        drain();
        if (fails == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

endmodule
